// File: hdl/hcdt_pkg.sv
// Shared types, codes and a helper function for the divider/timer block.
// Used by hcdt_core and by the top level; depends on nothing else.
package hcdt_pkg;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    localparam logic [1:0] REG_DIV  = 2'd0;
    localparam logic [1:0] REG_TIMA = 2'd1;
    localparam logic [1:0] REG_TMA  = 2'd2;
    localparam logic [1:0] REG_TAC  = 2'd3;

    localparam logic [2:0] RELOAD_DELAY = 3'd4;
    localparam logic [2:0] WINDOW_LEN   = 3'd4;

    typedef struct packed {
        logic [7:0] write_data;
        logic [1:0] reg_select;
        logic [1:0] mode;
    } item_t;

    typedef struct packed {
        logic       timer_irq;
        logic [7:0] read_data;
    } result_t;

    // Counter bit chosen by the TAC select field, gated by the enable bit.
    function automatic logic gated_bit(input logic [15:0] counter, input logic [7:0] control);
        logic b;
        begin
            unique case (control[1:0])
                2'd0:    b = counter[9];
                2'd1:    b = counter[3];
                2'd2:    b = counter[5];
                default: b = counter[7];
            endcase
            return b & control[2];
        end
    endfunction

endpackage

// File: hdl/hcdt_core.sv
// Timer state registers and the single-pass update for one item.
// Depends on hcdt_pkg for the item and result types and the codes.
module hcdt_core
    import hcdt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    output result_t result
);

    logic [15:0] cnt_reg, cnt_next;
    logic [7:0]  tima_reg, tima_next;
    logic [7:0]  tma_reg, tma_next;
    logic [7:0]  tac_reg, tac_next;
    logic [2:0]  delay_reg, delay_next;
    logic [2:0]  window_reg, window_next;
    logic        active_reg, active_next;
    logic        last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            tima_reg   <= '0;
            tma_reg    <= '0;
            tac_reg    <= '0;
            delay_reg  <= '0;
            window_reg <= '0;
            active_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            tima_reg   <= tima_next;
            tma_reg    <= tma_next;
            tac_reg    <= tac_next;
            delay_reg  <= delay_next;
            window_reg <= window_next;
            active_reg <= active_next;
            last_reg   <= last_next;
        end
    end

    always_comb
    begin
        logic now_bit;
        logic fall;
        cnt_next    = cnt_reg;
        tima_next   = tima_reg;
        tma_next    = tma_reg;
        tac_next    = tac_reg;
        delay_next  = delay_reg;
        window_next = window_reg;
        active_next = active_reg;
        last_next   = last_reg;
        result      = '0;
        now_bit     = 1'b0;
        fall        = 1'b0;
        if (step)
        begin
            unique case (item.mode)
                MODE_TICK:
                begin
                    if (window_next != 3'd0)
                    begin
                        window_next = window_next - 3'd1;
                        if (window_next == 3'd0)
                        begin
                            active_next = 1'b0;
                        end
                    end
                    if (delay_next != 3'd0)
                    begin
                        delay_next = delay_next - 3'd1;
                        if (delay_next == 3'd0)
                        begin
                            tima_next        = tma_reg;
                            result.timer_irq = 1'b1;
                            window_next      = WINDOW_LEN;
                            active_next      = 1'b1;
                        end
                    end
                    cnt_next  = cnt_reg + 16'd1;
                    now_bit   = gated_bit(cnt_next, tac_reg);
                    fall      = last_reg & ~now_bit;
                    last_next = now_bit;
                end
                MODE_READ:
                begin
                    unique case (item.reg_select)
                        REG_DIV:  result.read_data = cnt_reg[15:8];
                        REG_TIMA: result.read_data = tima_reg;
                        REG_TMA:  result.read_data = tma_reg;
                        default:  result.read_data = tac_reg;
                    endcase
                end
                MODE_WRITE:
                begin
                    unique case (item.reg_select)
                        REG_DIV:
                        begin
                            cnt_next  = '0;
                            now_bit   = gated_bit(16'd0, tac_reg);
                            fall      = last_reg & ~now_bit;
                            last_next = now_bit;
                        end
                        REG_TIMA:
                        begin
                            if (delay_reg != 3'd0)
                            begin
                                active_next = 1'b0;
                                delay_next  = '0;
                            end
                            if (window_reg != 3'd0)
                            begin
                                tima_next = tma_reg;
                            end
                            else
                            begin
                                tima_next = item.write_data;
                            end
                        end
                        REG_TMA:
                        begin
                            if (active_reg)
                            begin
                                tima_next = item.write_data;
                            end
                            tma_next = item.write_data;
                        end
                        default:
                        begin
                            now_bit   = gated_bit(cnt_reg, item.write_data);
                            fall      = last_reg & ~now_bit;
                            last_next = now_bit;
                            tac_next  = item.write_data;
                        end
                    endcase
                end
                default:
                begin
                    result = '0;
                end
            endcase
            if (fall)
            begin
                tima_next = tima_next + 8'd1;
                if (tima_next == 8'd0)
                begin
                    delay_next = RELOAD_DELAY;
                end
            end
        end
    end

endmodule

// File: hdl/handheld_console_divider_timer_core.sv
// Top level of the divider/timer block: input register, timer core, result register.
// Depends on hcdt_pkg and hcdt_core.
//
// Usage: each item on the slave stream is one clock tick, one register read or
// one register write, chosen by the mode in tuser; each item gives exactly one
// result item on the master stream carrying read data and the interrupt flag.
// An accepted item waits in the input register until the result register is free
// or being taken; there the core updates the timer state and forms the result,
// which is then held in the result register.
// One item is accepted in every cycle while results are taken; the rate is set
// by the core, which does the whole state update for an item in one pass.
// When the receiver stalls, the result register holds its item and the input
// register fills; the slave side then drops tready until the stall clears, and
// no item is lost or repeated.
// Reset clears the counter, all timer registers and both stages.
module handheld_console_divider_timer_core
    import hcdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] write_data
    input  logic [3:0]  s_axis_tuser,   // [1:0] mode, [3:2] reg_select
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [7:0] read_data, [8] timer_irq, rest zero
);

    item_t   item_reg;
    logic    in_valid_reg;
    result_t result_reg;
    logic    out_valid_reg;
    result_t core_result;
    logic    advance;

    assign advance       = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg.mode       <= s_axis_tuser[1:0];
            item_reg.reg_select <= s_axis_tuser[3:2];
            item_reg.write_data <= s_axis_tdata;
        end
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    hcdt_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .result (core_result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, result_reg.timer_irq, result_reg.read_data};

endmodule
